### rtl/clbh_pkg.sv
// Shared types and constants for the Cyrillic letter bigram histogram unit.
`default_nettype none
package clbh_pkg;

    localparam int SYM_COUNT   = 33;
    localparam int LET_COUNT   = 32;
    localparam int PAIR_DEPTH  = SYM_COUNT * SYM_COUNT;
    localparam int LPAIR_DEPTH = LET_COUNT * LET_COUNT;
    localparam int IDX_BITS    = 11;
    localparam int LIDX_BITS   = 10;

    localparam logic [5:0] SPACE_SYM = 6'd32;

    localparam logic [2:0] TBL_SYMBOL = 3'd0;
    localparam logic [2:0] TBL_PAIR_OV = 3'd1;
    localparam logic [2:0] TBL_PAIR_EV = 3'd2;
    localparam logic [2:0] TBL_LPAIR_OV = 3'd3;
    localparam logic [2:0] TBL_LPAIR_EV = 3'd4;
    localparam logic [2:0] TBL_LENGTH = 3'd5;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [2:0]  table_select;
        logic [10:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        saturated;
    } out_item_t;

    // One decoded operation handed from the front part to the back part.
    typedef struct packed {
        logic        is_read;
        logic [2:0]  table_select;
        logic [10:0] entry_index;
        logic        sym_valid;
        logic        is_space;
        logic [5:0]  sym;
        logic        pair_en;
        logic        pair_even;
        logic [10:0] pair_idx;
        logic        lpair_en;
        logic        lpair_even;
        logic [9:0]  lpair_idx;
        logic        len_with;
        logic        len_without;
    } op_t;

endpackage
`default_nettype wire

### rtl/clbh_front.sv
// Front part: normalizes text bytes, tracks stream state, builds counter updates.
`default_nettype none
module clbh_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  clbh_pkg::in_item_t in_item,
    output logic              op_valid,
    output clbh_pkg::op_t     op,
    input  wire               op_take
);
    import clbh_pkg::*;

    logic       last_space_reg, last_space_next;
    logic [4:0] prev_full_reg, prev_full_next;
    logic       prev_full_v_reg, prev_full_v_next;
    logic       full_odd_reg, full_odd_next;
    logic [4:0] prev_let_reg, prev_let_next;
    logic       prev_let_v_reg, prev_let_v_next;
    logic       let_odd_reg, let_odd_next;

    // A space maps to symbol 32, which does not fit 5 bits; keep a flag.
    logic prev_was_sp_reg, prev_was_sp_next;

    logic [7:0] raw;
    logic [7:0] folded;
    logic       to_space;
    logic       kept;
    logic       is_let;
    logic [4:0] let_sym;

    logic [10:0] pair_base;
    assign pair_base = prev_was_sp_reg ? 11'd1056 : 11'({6'd0, prev_full_reg} * 11'd33);

    always_comb
    begin
        raw = in_item.char_code;
        to_space = (raw >= 8'h30 && raw <= 8'h39) || raw == 8'h2E || raw == 8'h2C ||
                   raw == 8'h96 || raw == 8'h3F || raw == 8'h21 || raw == 8'h29 ||
                   raw == 8'h28 || raw == 8'h2D || raw == 8'h22 || raw == 8'h3A ||
                   raw == 8'h20;
        if (raw >= 8'hC0 && raw <= 8'hDF)
            folded = raw + 8'h20;
        else if (raw == 8'hA8 || raw == 8'hB8)
            folded = 8'hE5;
        else
            folded = raw;
        is_let = !to_space && folded >= 8'hE0;
        let_sym = folded[4:0];
        kept = raw != 8'h0A && !(to_space && last_space_reg);

        op = '0;
        op.is_read = in_item.command == CMD_READ;
        op.table_select = in_item.table_select;
        op.entry_index = in_item.entry_index;

        last_space_next = last_space_reg;
        prev_full_next = prev_full_reg;
        prev_full_v_next = prev_full_v_reg;
        full_odd_next = full_odd_reg;
        prev_let_next = prev_let_reg;
        prev_let_v_next = prev_let_v_reg;
        let_odd_next = let_odd_reg;

        if (!op.is_read && kept)
        begin
            op.sym_valid = to_space || is_let;
            op.is_space = to_space;
            op.sym = to_space ? SPACE_SYM : {1'b0, let_sym};
            op.pair_en = op.sym_valid && prev_full_v_reg;
            op.pair_even = full_odd_reg;
            op.pair_idx = pair_base + {5'd0, op.sym};
            op.len_with = 1'b1;
            prev_full_v_next = op.sym_valid;
            prev_full_next = to_space ? 5'd0 : (is_let ? let_sym : 5'd0);
            full_odd_next = !full_odd_reg;
            last_space_next = to_space;
            if (!to_space)
            begin
                op.lpair_en = is_let && prev_let_v_reg;
                op.lpair_even = let_odd_reg;
                op.lpair_idx = {prev_let_reg, let_sym};
                op.len_without = 1'b1;
                prev_let_v_next = is_let;
                prev_let_next = is_let ? let_sym : 5'd0;
                let_odd_next = !let_odd_reg;
            end
        end
    end

    always_comb
    begin
        prev_was_sp_next = prev_was_sp_reg;
        if (!op.is_read && kept)
            prev_was_sp_next = to_space;
    end

    always_comb
    begin
        op_valid = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_space_reg <= 1'b0;
            prev_full_reg <= '0;
            prev_full_v_reg <= 1'b0;
            full_odd_reg <= 1'b0;
            prev_let_reg <= '0;
            prev_let_v_reg <= 1'b0;
            let_odd_reg <= 1'b0;
            prev_was_sp_reg <= 1'b0;
        end
        else if (in_valid && op_take)
        begin
            last_space_reg <= last_space_next;
            prev_full_reg <= prev_full_next;
            prev_full_v_reg <= prev_full_v_next;
            full_odd_reg <= full_odd_next;
            prev_let_reg <= prev_let_next;
            prev_let_v_reg <= prev_let_v_next;
            let_odd_reg <= let_odd_next;
            prev_was_sp_reg <= prev_was_sp_next;
        end
    end
endmodule
`default_nettype wire

### rtl/clbh_queue.sv
// Short queue that decouples the front part from the back part.
`default_nettype none
module clbh_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            wr_valid,
    input  clbh_pkg::op_t  wr_op,
    output logic           wr_ready,
    output logic           rd_valid,
    output clbh_pkg::op_t  rd_op,
    input  wire            rd_ready
);
    import clbh_pkg::*;

    op_t        slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_op = slot_reg[rptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= !wptr_reg;
            if (do_rd)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end
endmodule
`default_nettype wire

### rtl/clbh_back.sv
// Back part: counter memories with clearing pass, forwarding and read results.
`default_nettype none
module clbh_back #(
    parameter int COUNT_BITS = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              op_valid,
    input  clbh_pkg::op_t    op,
    output logic             op_ready,
    output logic             out_valid,
    output clbh_pkg::out_item_t out_item,
    input  wire              out_ready,
    output logic             busy
);
    import clbh_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // Letter counters, the space counter and lengths are small enough for flip-flops.
    cnt_t sym_reg [LET_COUNT];
    cnt_t space_cnt_reg;
    cnt_t lenw_reg, lenwo_reg;
    cnt_t pov_mem [PAIR_DEPTH];
    cnt_t pev_mem [PAIR_DEPTH];
    cnt_t lov_mem [LPAIR_DEPTH];
    cnt_t lev_mem [LPAIR_DEPTH];

    // Clearing pass state.
    logic [IDX_BITS-1:0] clr_reg;
    logic                clr_busy_reg;

    // Stage 1: registered op and memory read data.
    logic  s1_v_reg;
    op_t   s1_op_reg;
    cnt_t  pov_q, pev_q, lov_q, lev_q;

    // Stage 2: write back.
    logic  s2_v_reg;
    op_t   s2_op_reg;
    cnt_t  pov_w_reg, pev_w_reg, lov_w_reg, lev_w_reg;

    // Writes that committed at the last edge, which the read data may not hold yet.
    logic  pov3_v_reg, pev3_v_reg, lov3_v_reg, lev3_v_reg;
    logic [IDX_BITS-1:0]  p3_idx_reg;
    logic [LIDX_BITS-1:0] l3_idx_reg;
    cnt_t  pov3_reg, pev3_reg, lov3_reg, lev3_reg;

    logic  res_v_reg;
    out_item_t res_reg;

    logic  adv;
    logic [IDX_BITS-1:0] pr_addr;
    logic [LIDX_BITS-1:0] lr_addr;
    logic [IDX_BITS-1:0] s1_pkey;
    logic [LIDX_BITS-1:0] s1_lkey;

    assign busy = clr_busy_reg;
    // A read result can be produced only if the output slot frees.
    assign adv = !clr_busy_reg && (!res_v_reg || out_ready || !(s1_v_reg && s1_op_reg.is_read));
    assign op_ready = adv;
    assign out_valid = res_v_reg;
    assign out_item = res_reg;

    assign pr_addr = op.is_read ? op.entry_index : op.pair_idx;
    assign lr_addr = op.is_read ? op.entry_index[LIDX_BITS-1:0] : op.lpair_idx;
    assign s1_pkey = s1_op_reg.is_read ? s1_op_reg.entry_index : s1_op_reg.pair_idx;
    assign s1_lkey = s1_op_reg.is_read ? s1_op_reg.entry_index[LIDX_BITS-1:0]
                                       : s1_op_reg.lpair_idx;

    function automatic cnt_t bump(input cnt_t c);
        bump = (c == CNT_MAX) ? c : c + cnt_t'(1);
    endfunction

    // Stage 1 values after forwarding from the write-back stage and the last write.
    cnt_t pov_f, pev_f, lov_f, lev_f;
    cnt_t pov_n, pev_n, lov_n, lev_n;
    always_comb
    begin
        pov_f = (s2_v_reg && s2_op_reg.pair_en && s2_op_reg.pair_idx == s1_pkey) ? pov_w_reg
                : (pov3_v_reg && p3_idx_reg == s1_pkey) ? pov3_reg : pov_q;
        pev_f = (s2_v_reg && s2_op_reg.pair_en && s2_op_reg.pair_even &&
                 s2_op_reg.pair_idx == s1_pkey) ? pev_w_reg
                : (pev3_v_reg && p3_idx_reg == s1_pkey) ? pev3_reg : pev_q;
        lov_f = (s2_v_reg && s2_op_reg.lpair_en && s2_op_reg.lpair_idx == s1_lkey) ? lov_w_reg
                : (lov3_v_reg && l3_idx_reg == s1_lkey) ? lov3_reg : lov_q;
        lev_f = (s2_v_reg && s2_op_reg.lpair_en && s2_op_reg.lpair_even &&
                 s2_op_reg.lpair_idx == s1_lkey) ? lev_w_reg
                : (lev3_v_reg && l3_idx_reg == s1_lkey) ? lev3_reg : lev_q;
        pov_n = bump(pov_f);
        pev_n = bump(pev_f);
        lov_n = bump(lov_f);
        lev_n = bump(lev_f);
    end

    // Read result selection for a read op in stage 1.
    cnt_t rd_val;
    logic rd_hit;
    always_comb
    begin
        rd_val = '0;
        rd_hit = 1'b0;
        unique case (s1_op_reg.table_select)
            TBL_SYMBOL:
                if (s1_op_reg.entry_index < 11'(SYM_COUNT))
                begin
                    rd_val = (s1_op_reg.entry_index == {5'd0, SPACE_SYM}) ? space_cnt_reg
                             : sym_reg[s1_op_reg.entry_index[4:0]];
                    rd_hit = 1'b1;
                end
            TBL_PAIR_OV:
                if (s1_op_reg.entry_index < 11'(PAIR_DEPTH))
                begin
                    rd_val = pov_f;
                    rd_hit = 1'b1;
                end
            TBL_PAIR_EV:
                if (s1_op_reg.entry_index < 11'(PAIR_DEPTH))
                begin
                    rd_val = pev_f;
                    rd_hit = 1'b1;
                end
            TBL_LPAIR_OV:
                if (s1_op_reg.entry_index < 11'(LPAIR_DEPTH))
                begin
                    rd_val = lov_f;
                    rd_hit = 1'b1;
                end
            TBL_LPAIR_EV:
                if (s1_op_reg.entry_index < 11'(LPAIR_DEPTH))
                begin
                    rd_val = lev_f;
                    rd_hit = 1'b1;
                end
            TBL_LENGTH:
                if (s1_op_reg.entry_index < 11'd2)
                begin
                    rd_val = s1_op_reg.entry_index[0] ? lenwo_reg : lenw_reg;
                    rd_hit = 1'b1;
                end
            default:
            begin
                rd_val = '0;
                rd_hit = 1'b0;
            end
        endcase
    end

    // Memory ports: one read address and one write address each.
    // While stage 1 waits, its read data follows the writes that go on meanwhile.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pov_q <= pov_mem[pr_addr < 11'(PAIR_DEPTH) ? pr_addr : '0];
            pev_q <= pev_mem[pr_addr < 11'(PAIR_DEPTH) ? pr_addr : '0];
            lov_q <= lov_mem[lr_addr];
            lev_q <= lev_mem[lr_addr];
        end
        else
        begin
            pov_q <= pov_f;
            pev_q <= pev_f;
            lov_q <= lov_f;
            lev_q <= lev_f;
        end
        if (clr_busy_reg)
        begin
            pov_mem[clr_reg] <= '0;
            pev_mem[clr_reg] <= '0;
            lov_mem[clr_reg[LIDX_BITS-1:0]] <= '0;
            lev_mem[clr_reg[LIDX_BITS-1:0]] <= '0;
        end
        else if (s2_v_reg)
        begin
            if (s2_op_reg.pair_en)
                pov_mem[s2_op_reg.pair_idx] <= pov_w_reg;
            if (s2_op_reg.pair_en && s2_op_reg.pair_even)
                pev_mem[s2_op_reg.pair_idx] <= pev_w_reg;
            if (s2_op_reg.lpair_en)
                lov_mem[s2_op_reg.lpair_idx] <= lov_w_reg;
            if (s2_op_reg.lpair_en && s2_op_reg.lpair_even)
                lev_mem[s2_op_reg.lpair_idx] <= lev_w_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= op;
            s2_op_reg <= s1_op_reg;
            pov_w_reg <= pov_n;
            pev_w_reg <= pev_n;
            lov_w_reg <= lov_n;
            lev_w_reg <= lev_n;
        end
        p3_idx_reg <= s2_op_reg.pair_idx;
        l3_idx_reg <= s2_op_reg.lpair_idx;
        pov3_reg <= pov_w_reg;
        pev3_reg <= pev_w_reg;
        lov3_reg <= lov_w_reg;
        lev3_reg <= lev_w_reg;
        if (adv && s1_v_reg && s1_op_reg.is_read)
        begin
            res_reg.count_value <= 32'(rd_val);
            res_reg.saturated <= rd_hit && rd_val == CNT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            clr_busy_reg <= 1'b1;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            pov3_v_reg <= 1'b0;
            pev3_v_reg <= 1'b0;
            lov3_v_reg <= 1'b0;
            lev3_v_reg <= 1'b0;
            res_v_reg <= 1'b0;
            lenw_reg <= '0;
            lenwo_reg <= '0;
            space_cnt_reg <= '0;
            for (int i = 0; i < LET_COUNT; i++)
                sym_reg[i] <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + 11'd1;
                if (clr_reg == 11'(PAIR_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            pov3_v_reg <= s2_v_reg && s2_op_reg.pair_en;
            pev3_v_reg <= s2_v_reg && s2_op_reg.pair_en && s2_op_reg.pair_even;
            lov3_v_reg <= s2_v_reg && s2_op_reg.lpair_en;
            lev3_v_reg <= s2_v_reg && s2_op_reg.lpair_en && s2_op_reg.lpair_even;
            if (adv && s1_v_reg && s1_op_reg.is_read)
                res_v_reg <= 1'b1;
            else if (out_valid && out_ready)
                res_v_reg <= 1'b0;
            if (adv)
            begin
                s1_v_reg <= op_valid;
                s2_v_reg <= s1_v_reg && !s1_op_reg.is_read;
                if (s1_v_reg && !s1_op_reg.is_read)
                begin
                    if (s1_op_reg.sym_valid)
                    begin
                        if (s1_op_reg.is_space)
                            space_cnt_reg <= bump(space_cnt_reg);
                        else
                            sym_reg[s1_op_reg.sym[4:0]] <= bump(sym_reg[s1_op_reg.sym[4:0]]);
                    end
                    if (s1_op_reg.len_with)
                        lenw_reg <= bump(lenw_reg);
                    if (s1_op_reg.len_without)
                        lenwo_reg <= bump(lenwo_reg);
                end
            end
            else
                s2_v_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### rtl/cyrillic_letter_bigram_histogram_unit.sv
// Read path: a read request passes the queue, stage 1 and the result register.
// Throughput: one request per cycle while no clearing pass runs and no read result
// waits on out_ready; feeds update each counter memory at most once per byte
// through a read, bump and write-back pipeline with forwarding. Reset: control
// state clears at once; a clearing pass then zeroes the pair memories, during which no request is accepted.
`default_nettype none
module cyrillic_letter_bigram_histogram_unit #(
    parameter int COUNT_BITS = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  clbh_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output clbh_pkg::out_item_t  out_data
);
    import clbh_pkg::*;

    logic q_in_ready, f_valid, q_valid, b_ready, busy;
    op_t  f_op, q_op;

    assign in_ready = q_in_ready && !busy;

    clbh_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid && !busy), .in_item(in_data),
        .op_valid(f_valid), .op(f_op), .op_take(q_in_ready)
    );

    clbh_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_op(f_op),
        .wr_ready(q_in_ready), .rd_valid(q_valid), .rd_op(q_op), .rd_ready(b_ready)
    );

    clbh_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .op_valid(q_valid), .op(q_op), .op_ready(b_ready),
        .out_valid(out_valid), .out_item(out_data), .out_ready(out_ready), .busy(busy)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("request accepted during clearing pass");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
